>>> design/binary_heap_priority_queue_core_assert.svh
// Assertion helpers shared by the heap RTL.
// Both macros clock on clk and hold off while rst_n is low.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bhpq_pkg.sv
package bhpq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Input command codes
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Register map
    localparam logic [1:0] ADDR_ORDER_MODE = 2'd0;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R,
        ST_DN_W,
        ST_RESULT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_CUR,
        WR_PARENT,
        WR_BEST
    } wr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_status;
        status_t res_status;
        logic    load_ins;
        logic    load_ext;
        logic    load_cur;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_parent;
        logic    pos_best;
        logic    eval_left;
        logic    eval_right;
        logic    set_result;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic has_left;
        logic has_right;
        logic up_wins;
        logic dn_moved;
        logic out_free;
    } dp_stat_t;

endpackage

>>> design/binary_heap_priority_queue_core.sv
// Channel  Side    Beat contents (lowest bit first)
// -------  ------  --------------------------------------------------------------
// s_*      in      tuser: command; tdata: key
// m_*      out     tuser: status; tdata: extracted_key, top_key, top_valid,
//                  entry_count, zero fill
// apb      config  order_mode at byte address 0, write taken only while empty
//
// Insert climbs level by level: read the parent, then compare and write.
// Extract descends level by level: read left, read right if present, then write.
// The single read port of the key store and its registered read set the cost of
// each level. Reset empties the heap at once: the store itself is never cleared,
// since no entry beyond the count is read. One item is in flight at a time; a
// finished result waits in the output register while the next beat is taken.
module binary_heap_priority_queue_core import bhpq_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int CW     = $clog2(CAPACITY + 1),
    localparam int IN_DW  = ((KEY_WIDTH + 7) / 8) * 8,
    localparam int OUT_W  = 2 * KEY_WIDTH + 1 + CW,
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // key
    input  logic [0:0]        s_tuser,   // command

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // extracted_key, top_key, top_valid, entry_count
    output logic [1:0]        m_tuser    // status
);

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic                 order_mode_reg;
    logic                 cfg_wr;
    status_t              out_status;
    logic [KEY_WIDTH-1:0] out_extracted_key;
    logic [KEY_WIDTH-1:0] out_top_key;
    logic                 out_top_valid;
    logic [CW-1:0]        out_entry_count;

    // Drop order changes while entries are held: the heap would lose its shape
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ORDER_MODE) && stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            order_mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ORDER_MODE) ? {31'b0, order_mode_reg} : '0;

    bhpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser[0]),
        .stat       (stat),
        .in_ready   (s_tready),
        .cmd        (cmd)
    );

    bhpq_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_key            (s_tdata[KEY_WIDTH-1:0]),
        .order_mode        (order_mode_reg),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_status        (out_status),
        .out_extracted_key (out_extracted_key),
        .out_top_key       (out_top_key),
        .out_top_valid     (out_top_valid),
        .out_entry_count   (out_entry_count)
    );

    // Pack the result beat, zero fill up to whole bytes
    assign m_tdata = OUT_DW'({out_entry_count, out_top_valid, out_top_key, out_extracted_key});
    assign m_tuser = out_status;

endmodule

>>> design/bhpq_ram.sv
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bhpq_datapath.sv
`include "binary_heap_priority_queue_core_assert.svh"

module bhpq_datapath import bhpq_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int IW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic                 order_mode,
    input  logic                 out_ready,
    output logic                 out_valid,
    output status_t              out_status,
    output logic [KEY_WIDTH-1:0] out_extracted_key,
    output logic [KEY_WIDTH-1:0] out_top_key,
    output logic                 out_top_valid,
    output logic [IW-1:0]        out_entry_count
);

    localparam logic [IW-1:0] CAP_VAL = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE     = IW'(1);

    logic [IW-1:0]        count_reg;
    logic [IW-1:0]        pos_reg;
    logic [KEY_WIDTH-1:0] cur_reg;
    logic [KEY_WIDTH-1:0] best_val_reg;
    logic [IW-1:0]        best_idx_reg;
    logic                 moved_reg;
    logic [KEY_WIDTH-1:0] root_reg;
    status_t              status_reg;
    logic [KEY_WIDTH-1:0] ext_reg;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [KEY_WIDTH-1:0] m_ext_reg;
    logic [KEY_WIDTH-1:0] m_top_reg;
    logic                 m_top_valid_reg;
    logic [IW-1:0]        m_count_reg;

    logic [IW:0]          left_idx;
    logic [IW:0]          right_idx;
    logic [IW:0]          rd_idx;
    logic [IW:0]          wr_idx;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 left_wins;
    logic                 right_wins;
    logic                 fin_moved;
    logic [KEY_WIDTH-1:0] fin_val;
    logic [IW-1:0]        fin_idx;

    // a ranks strictly above b under the selected order
    function automatic logic outranks(input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b,
                                      input logic                 mode);
        logic r;
        r = mode ? (a < b) : (a > b);
        return r;
    endfunction

    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};

    assign left_wins  = outranks(rd_data, cur_reg, order_mode);
    assign right_wins = cmd.eval_right && outranks(rd_data, best_val_reg, order_mode);

    assign fin_moved = right_wins || moved_reg;
    assign fin_val   = right_wins ? rd_data : best_val_reg;
    assign fin_idx   = right_wins ? right_idx[IW-1:0] : best_idx_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PARENT: rd_idx = {2'b00, pos_reg[IW-1:1]};
            RD_LAST:   rd_idx = {1'b0, count_reg};
            RD_LEFT:   rd_idx = left_idx;
            RD_RIGHT:  rd_idx = right_idx;
            default:   rd_idx = {1'b0, count_reg};
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_CUR:    wr_data = cur_reg;
            WR_PARENT: wr_data = rd_data;
            WR_BEST:   wr_data = fin_val;
            default:   wr_data = cur_reg;
        endcase
    end

    // Store positions are one-based; RAM rows are zero-based
    assign wr_idx  = {1'b0, pos_reg} - (IW + 1)'(1);
    assign rd_addr = AW'(rd_idx - (IW + 1)'(1));
    assign wr_addr = wr_idx[AW-1:0];

    bhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            moved_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_ins)
            begin
                count_reg <= count_reg + ONE;
            end
            else if (cmd.load_ext)
            begin
                count_reg <= count_reg - ONE;
            end

            if (cmd.eval_left)
            begin
                moved_reg <= left_wins;
            end

            if (cmd.set_result)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            status_reg <= cmd.res_status;
            // carry the old root out on an extract, zero otherwise
            ext_reg    <= cmd.load_ext ? root_reg : '0;
        end
        if (cmd.load_ins)
        begin
            pos_reg <= count_reg + ONE;
            cur_reg <= in_key;
        end
        if (cmd.load_cur)
        begin
            cur_reg <= rd_data;
            pos_reg <= ONE;
        end
        if (cmd.pos_parent)
        begin
            pos_reg <= pos_reg >> 1;
        end
        if (cmd.pos_best)
        begin
            pos_reg <= fin_idx;
        end
        if (cmd.eval_left)
        begin
            best_val_reg <= left_wins ? rd_data : cur_reg;
            best_idx_reg <= left_idx[IW-1:0];
        end
        // Mirror the root so top and extract need no extra read
        if (cmd.wr_en && (pos_reg == ONE))
        begin
            root_reg <= wr_data;
        end
        if (cmd.set_result)
        begin
            m_status_reg    <= status_reg;
            m_ext_reg       <= ext_reg;
            m_top_reg       <= (count_reg != '0) ? root_reg : '0;
            m_top_valid_reg <= (count_reg != '0);
            m_count_reg     <= count_reg;
        end
    end

    assign stat.full      = (count_reg >= CAP_VAL);
    assign stat.empty     = (count_reg == '0);
    assign stat.at_root   = (pos_reg == ONE);
    assign stat.has_left  = (left_idx <= {1'b0, count_reg});
    assign stat.has_right = (right_idx <= {1'b0, count_reg});
    assign stat.up_wins   = outranks(cur_reg, rd_data, order_mode);
    assign stat.dn_moved  = fin_moved;
    assign stat.out_free  = !m_valid_reg || out_ready;

    assign out_valid         = m_valid_reg;
    assign out_status        = m_status_reg;
    assign out_extracted_key = m_ext_reg;
    assign out_top_key       = m_top_reg;
    assign out_top_valid     = m_top_valid_reg;
    assign out_entry_count   = m_count_reg;

    `BHPQ_ASSERT_NOW(a_count_max, 1'b1, count_reg <= CAP_VAL, "entry count above capacity")
    `BHPQ_ASSERT_NOW(a_wr_in_heap, cmd.wr_en,
        (pos_reg != '0) && ((pos_reg <= count_reg) || (pos_reg == ONE)),
        "store write outside the live heap")
    `BHPQ_ASSERT_NEXT(a_result_valid, cmd.set_result, m_valid_reg,
        "result not presented after completion")
    `BHPQ_ASSERT_NEXT(a_insert_grows, cmd.load_ins, count_reg == $past(count_reg) + ONE,
        "insert did not grow the heap by one")

endmodule

>>> design/bhpq_ctrl.sv
module bhpq_ctrl import bhpq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_command,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_status = 1'b1;
                    if (in_command == CMD_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = STATUS_FULL;
                            state_next     = ST_RESULT;
                        end
                        else
                        begin
                            cmd.res_status = STATUS_OK;
                            cmd.load_ins   = 1'b1;
                            state_next     = ST_UP_CHK;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.res_status = STATUS_EMPTY;
                        state_next     = ST_RESULT;
                    end
                    else
                    begin
                        // fetch the last entry, it moves to the root
                        cmd.res_status = STATUS_OK;
                        cmd.load_ext   = 1'b1;
                        cmd.rd_en      = 1'b1;
                        cmd.rd_sel     = RD_LAST;
                        state_next     = ST_DN_LOAD;
                    end
                end
            end
            ST_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_CUR;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.up_wins)
                begin
                    // pull the parent down, climb one level
                    cmd.wr_sel     = WR_PARENT;
                    cmd.pos_parent = 1'b1;
                    state_next     = ST_UP_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = ST_RESULT;
                end
            end
            ST_DN_LOAD:
            begin
                cmd.load_cur = 1'b1;
                state_next   = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (stat.has_left)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LEFT;
                    state_next = ST_DN_L;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_CUR;
                    state_next = ST_RESULT;
                end
            end
            ST_DN_L:
            begin
                cmd.eval_left = 1'b1;
                if (stat.has_right)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_RIGHT;
                    state_next = ST_DN_R;
                end
                else
                begin
                    state_next = ST_DN_W;
                end
            end
            ST_DN_R, ST_DN_W:
            begin
                cmd.eval_right = (state_reg == ST_DN_R);
                cmd.wr_en      = 1'b1;
                if (stat.dn_moved)
                begin
                    // lift the winning child, descend into its slot
                    cmd.wr_sel   = WR_BEST;
                    cmd.pos_best = 1'b1;
                    state_next   = ST_DN_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
